// ===== src/kt_pkg.sv =====
// shared types, token codes, character classes and keyword table of the tokenizer
package kt_pkg;

  localparam int TEXT_LIMIT_DEFAULT  = 255;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int PREFIX_DEPTH        = 7;
  localparam int KW_COUNT            = 51;

  localparam logic [6:0] TOK_EOF     = 7'd0;
  localparam logic [6:0] TOK_ID      = 7'd1;
  localparam logic [6:0] TOK_NUMERAL = 7'd2;
  localparam logic [6:0] TOK_STRING  = 7'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic       RES_TEXT    = 1'b0;
  localparam logic       RES_END     = 1'b1;
  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_EOF    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] text_char;
    logic [6:0] token_type;
    logic [7:0] token_length;
    logic       last;
  } out_item_t;

  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

  // one queue entry: up to three results in the order close, text, tail
  typedef struct packed {
    logic       close_v;
    logic       close_kw;
    logic [6:0] close_type;
    logic [7:0] close_len;
    logic [2:0] key_len;
    prefix_t    key;
    logic       text_v;
    logic [7:0] text_char;
    logic       tail_v;
    logic [6:0] tail_type;
    logic [7:0] tail_len;
  } kt_entry_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] tok;
  } punct_t;

  localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
    "program", "def", "repeat", "turn", "on", "off", "wait", "forever",
    "if", "else", "make", "var", "set", "change", "to", "by",
    "read", "analog", "pulse", "serial", "servo", "print", "tone", "notone",
    "freq", "return", "while", "break", "array", "size", "index", "of",
    "i2c", "begin", "start", "send", "stop", "pin", "is", "high",
    "low", "and", "or", "sin", "cos", "tan", "sqrt", "acos",
    "asin", "atan", "atan2"
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd7, 3'd3, 3'd6, 3'd4, 3'd2, 3'd3, 3'd4, 3'd7,
    3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd6, 3'd2, 3'd2,
    3'd4, 3'd6, 3'd5, 3'd6, 3'd5, 3'd5, 3'd4, 3'd6,
    3'd4, 3'd6, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd2,
    3'd3, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2, 3'd4,
    3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd5
  };

  localparam logic [6:0] KW_TYPE [KW_COUNT] = '{
    7'd4,  7'd28, 7'd29, 7'd11, 7'd12, 7'd13, 7'd14, 7'd20,
    7'd21, 7'd22, 7'd17, 7'd52, 7'd15, 7'd18, 7'd16, 7'd19,
    7'd23, 7'd24, 7'd25, 7'd42, 7'd26, 7'd27, 7'd30, 7'd31,
    7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39,
    7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50,
    7'd51, 7'd69, 7'd70, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
    7'd58, 7'd59, 7'd60
  };

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic punct_t punct_lookup(logic [7:0] c);
    punct_t p;
    p.hit = 1'b1;
    case (c)
      "(":     p.tok = 7'd8;
      ")":     p.tok = 7'd9;
      "[":     p.tok = 7'd40;
      "]":     p.tok = 7'd41;
      ",":     p.tok = 7'd10;
      "{":     p.tok = 7'd5;
      "}":     p.tok = 7'd6;
      "=":     p.tok = 7'd61;
      "<":     p.tok = 7'd63;
      ">":     p.tok = 7'd64;
      "+":     p.tok = 7'd65;
      "-":     p.tok = 7'd66;
      "*":     p.tok = 7'd67;
      "/":     p.tok = 7'd68;
      default: begin
        p.hit = 1'b0;
        p.tok = TOK_ID;
      end
    endcase
    return p;
  endfunction

  // right-aligned packing of the first len bytes, then a match against every keyword
  function automatic logic [6:0] kw_lookup(prefix_t key, logic [2:0] len);
    logic [55:0] word;
    logic [6:0]  tok;
    word = '0;
    tok  = TOK_ID;
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      if (3'(i) < len) begin
        word = {word[47:0], key[i]};
      end
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      if (KW_LEN[k] == len && KW_TEXT[k] == word) begin
        tok = KW_TYPE[k];
      end
    end
    return tok;
  endfunction

endpackage

// ===== src/kt_stream_if.sv =====
// valid/ready stream channel with a typed payload
interface kt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/kt_front.sv =====
// front end: scanner state machine that classifies input items into queue entries
module kt_front #(
  parameter int TEXT_LIMIT = kt_pkg::TEXT_LIMIT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kt_stream_if.sink         in_i,
  input  logic              full_i,
  output logic              push_o,
  output kt_pkg::kt_entry_t entry_o
);
  import kt_pkg::*;

  localparam int CW = $clog2(TEXT_LIMIT + 1);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_STRING  = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           pt_q, pt_d;
  logic           hx_q, hx_d;
  prefix_t        prefix_q;

  logic           pf_we;
  logic [2:0]     pf_idx;
  logic           fresh;
  logic           do_close;
  logic           num_ok;
  logic           accept;
  logic [7:0]     c;
  punct_t         pc;
  kt_entry_t      ent;

  assign c         = in_i.data.char_code;
  assign pc        = punct_lookup(c);
  assign in_i.ready = !full_i;
  assign accept    = in_i.valid && !full_i;
  assign num_ok    = is_digit(c) || (c == CH_DOT && !pt_q) || (c == CH_X && !hx_q) ||
                     (hx_q && is_hex(c));

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    pt_d     = pt_q;
    hx_d     = hx_q;
    pf_we    = 1'b0;
    pf_idx   = '0;
    fresh    = 1'b0;
    do_close = 1'b0;
    ent           = '0;
    ent.key       = prefix_q;
    ent.key_len   = cnt_q[2:0];
    ent.close_len = 8'(cnt_q);

    if (in_i.data.kind == KIND_EOF) begin
      do_close      = 1'b1;
      ent.tail_v    = 1'b1;
      ent.tail_type = TOK_EOF;
      ent.tail_len  = '0;
    end else begin
      case (mode_q)
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            do_close = 1'b1;
          end else if (cnt_q < CW'(TEXT_LIMIT)) begin
            ent.text_v    = 1'b1;
            ent.text_char = c;
            cnt_d         = cnt_q + CW'(1);
          end else begin
            do_close = 1'b1;
            fresh    = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_word(c) && cnt_q < CW'(TEXT_LIMIT)) begin
            if (cnt_q < CW'(PREFIX_DEPTH)) begin
              pf_we  = 1'b1;
              pf_idx = cnt_q[2:0];
            end
            ent.text_v    = 1'b1;
            ent.text_char = c;
            cnt_d         = cnt_q + CW'(1);
          end else begin
            do_close = 1'b1;
            fresh    = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (num_ok && cnt_q < CW'(TEXT_LIMIT)) begin
            if (c == CH_DOT) pt_d = 1'b1;
            if (c == CH_X) hx_d = 1'b1;
            ent.text_v    = 1'b1;
            ent.text_char = c;
            cnt_d         = cnt_q + CW'(1);
          end else begin
            do_close = 1'b1;
            fresh    = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) mode_d = MODE_IDLE;
        end
        default: begin
          fresh = 1'b1;
        end
      endcase
    end

    if (do_close) begin
      case (mode_q)
        MODE_IDENT: begin
          ent.close_v = 1'b1;
          // longer than the prefix store is never a keyword
          if (cnt_q <= CW'(PREFIX_DEPTH)) ent.close_kw = 1'b1;
          else ent.close_type = TOK_ID;
        end
        MODE_NUMBER: begin
          ent.close_v    = 1'b1;
          ent.close_type = TOK_NUMERAL;
        end
        MODE_STRING: begin
          ent.close_v    = 1'b1;
          ent.close_type = TOK_STRING;
        end
        default: ent.close_v = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      cnt_d  = '0;
    end

    if (fresh) begin
      mode_d = MODE_IDLE;
      cnt_d  = '0;
      pt_d   = 1'b0;
      hx_d   = 1'b0;
      if (is_space(c)) begin
        mode_d = MODE_IDLE;
      end else if (c == CH_QUOTE) begin
        mode_d = MODE_STRING;
      end else if (pc.hit) begin
        ent.text_v    = 1'b1;
        ent.text_char = c;
        ent.tail_v    = 1'b1;
        ent.tail_type = pc.tok;
        ent.tail_len  = 8'd1;
      end else if (is_alpha(c) || c == CH_UNDER) begin
        mode_d        = MODE_IDENT;
        pf_we         = 1'b1;
        pf_idx        = '0;
        cnt_d         = CW'(1);
        ent.text_v    = 1'b1;
        ent.text_char = c;
      end else if (is_digit(c)) begin
        mode_d        = MODE_NUMBER;
        cnt_d         = CW'(1);
        ent.text_v    = 1'b1;
        ent.text_char = c;
      end else if (c == CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else begin
        ent.text_v    = 1'b1;
        ent.text_char = c;
        ent.tail_v    = 1'b1;
        ent.tail_type = TOK_ID;
        ent.tail_len  = 8'd1;
      end
    end
  end

  assign entry_o = ent;
  assign push_o  = accept && (ent.close_v || ent.text_v || ent.tail_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      pt_q   <= 1'b0;
      hx_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      pt_q   <= pt_d;
      hx_q   <= hx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pf_we) begin
      prefix_q[pf_idx] <= c;
    end
  end

endmodule

// ===== src/kt_fifo.sv =====
// short queue of classified entries between front and back end
module kt_fifo #(
  parameter int DEPTH = kt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kt_pkg::kt_entry_t entry_i,
  input  logic              pop_i,
  output kt_pkg::kt_entry_t head_o,
  output logic              full_o,
  output logic              empty_o
);
  import kt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  kt_entry_t     mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] num_q;
  logic          do_push, do_pop;

  assign full_o  = (num_q == NW'(DEPTH));
  assign empty_o = (num_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop) num_q <= num_q + NW'(1);
      else if (do_pop && !do_push) num_q <= num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule

// ===== src/kt_back.sv =====
// back end: resolves keywords, sends results one per cycle unless out_o stalls
module kt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kt_pkg::kt_entry_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  kt_stream_if.source       out_o
);
  import kt_pkg::*;

  logic [2:0] done_q, done_d;
  logic [2:0] slots, pend, cur;
  logic       is_last;
  logic       load;
  logic       ov_q;
  out_item_t  data_q, data_d;

  assign slots   = {head_i.tail_v, head_i.text_v, head_i.close_v};
  assign pend    = slots & ~done_q;
  assign cur     = {pend[2] & ~pend[1] & ~pend[0], pend[1] & ~pend[0], pend[0]};
  assign is_last = ((pend & ~cur) == 3'b000);
  assign load    = (!ov_q || out_o.ready) && !empty_i;
  assign pop_o   = load && is_last;
  assign done_d  = is_last ? 3'b000 : (done_q | cur);

  always_comb begin
    data_d      = '0;
    data_d.last = is_last;
    if (cur[0]) begin
      data_d.result_kind  = RES_END;
      data_d.token_type   = head_i.close_kw ? kw_lookup(head_i.key, head_i.key_len)
                                            : head_i.close_type;
      data_d.token_length = head_i.close_len;
    end else if (cur[1]) begin
      data_d.result_kind = RES_TEXT;
      data_d.text_char   = head_i.text_char;
    end else begin
      data_d.result_kind  = RES_END;
      data_d.token_type   = head_i.tail_type;
      data_d.token_length = head_i.tail_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      done_q <= '0;
    end else begin
      if (load) begin
        ov_q   <= 1'b1;
        done_q <= done_d;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= data_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = data_q;

endmodule

// ===== src/keyword_tokenizer.sv =====
// top level of the streaming keyword tokenizer
//
// in_i carries one item per handshake: a source byte (kind 0) or an end-of-input
// mark (kind 1). out_o carries result items: token text bytes and token ends with
// type code and length; last marks the final result caused by one input item.
// The front end classifies one input item per cycle, while the queue is not full,
// into a queue entry of up to three results; the back end turns entries into
// results, one per cycle while out_o is taken, through an output register.
// The first result of an item is written into the queue and then into the output
// register before out_o shows it as valid.
// Input items flow at one per cycle while each causes at most one result and
// out_o is taken; the output port, one result per cycle, bounds the rate, so items
// with two or three results (punctuation, terminating bytes, end of input) take
// more output than input, and the QUEUE_DEPTH entry queue absorbs such bursts.
// Items that cause no result (whitespace, comments, opening quotes) push no entry.
// Reset: the scanner is idle between tokens, the queue is empty and out_o is not
// valid; the keyword prefix store is not cleared and needs no clearing pass.
// A stalled receiver holds the output register; the queue fills and in_i.ready
// drops once it is full.
module keyword_tokenizer #(
  parameter int TEXT_LIMIT  = kt_pkg::TEXT_LIMIT_DEFAULT,
  parameter int QUEUE_DEPTH = kt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kt_stream_if.sink   in_i,
  kt_stream_if.source out_o
);
  import kt_pkg::*;

  kt_entry_t entry, head;
  logic      push, pop, full, empty;

  kt_front #(
    .TEXT_LIMIT(TEXT_LIMIT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .entry_o(entry)
  );

  kt_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  kt_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // the queue never takes an entry when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("queue push while full");

  // the back end never drains an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("queue pop while empty");

  // an accepted item with a result lands in the queue by the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> !empty)
    else $error("queue empty after push");

  // an end-of-input token is always the final result of its item and has no text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.result_kind == RES_END && out_o.data.token_type == TOK_EOF)
      |-> (out_o.data.last && out_o.data.token_length == 8'd0))
    else $error("end-of-input token malformed");

  // text results carry no type or length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.result_kind == RES_TEXT)
      |-> (out_o.data.token_type == TOK_EOF && out_o.data.token_length == 8'd0))
    else $error("text result with type or length");

endmodule
